@@ sv/assert_macros.svh @@
// Assertion macros shared by the sprite blitter RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted
`define SBCK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define SBCK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/sbck_pkg.sv @@
// Shared constants, register codes and helpers for the sprite blitter.
// No dependencies.
package sbck_pkg;

    // Screen and sprite limits
    localparam int SCREEN_WIDTH    = 320;
    localparam int SCREEN_HEIGHT   = 240;
    localparam int MAX_SPRITE_SIDE = 256;

    // Fixed field widths
    localparam int DEST_W  = 11;
    localparam int SIDE_W  = 9;
    localparam int MODE_W  = 2;
    localparam int COLOR_W = 16;
    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    // Sprite position counters
    localparam int CNT_W = $clog2(MAX_SPRITE_SIDE);

    // Destination coordinate: signed origin plus unsigned offset, with headroom
    localparam int COORD_W = ((CNT_W > DEST_W - 1) ? CNT_W : DEST_W - 1) + 2;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_DEST_X          = 3'd0,
        REG_DEST_Y          = 3'd1,
        REG_SPRITE_WIDTH    = 3'd2,
        REG_SPRITE_HEIGHT   = 3'd3,
        REG_BLIT_MODE       = 3'd4,
        REG_TRANSPARENT_KEY = 3'd5,
        REG_FILL_COLOR      = 3'd6
    } cfg_reg_t;

    // Blit modes; the unused code behaves as a keyed copy
    localparam logic [MODE_W-1:0] MODE_KEYED  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FILL   = 2'd2;

    // Last index along a side; zero or oversize sides use the maximum
    function automatic logic [CNT_W-1:0] side_last(input logic [SIDE_W-1:0] side);
        logic [CNT_W-1:0] res;
        if (side == '0 || int'(side) > MAX_SPRITE_SIDE)
            res = CNT_W'(MAX_SPRITE_SIDE - 1);
        else
            res = CNT_W'(side - 1'b1);
        return res;
    endfunction

endpackage

@@ sv/sprite_blitter_clip_key_top.sv @@
// Color-key sprite blitter with screen clipping, single-stage pipeline.
// Depends on sbck_pkg and assert_macros.svh.
//
// Usage:
//   Load the sprite registers through cfg_we / cfg_index / cfg_data while the
//   block is idle, then stream sprite pixels in row-major order on the input
//   channel (in_valid, in_stall, src_color). Each word yields one result word
//   on the output channel (out_valid, out_stall, write_en, screen_x, screen_y,
//   out_color, sprite_done). Pixels that fall off screen, or match the key
//   outside fill mode, come out with write_en low and zero coordinates and color.
//   The result is registered: out_valid rises in the cycle after acceptance.
//   Throughput: one word per cycle except while a full result register stalls;
//   destination math, clip test and color select sit between the input port and
//   the result register; only the column and row counters carry over between words.
//   A stalled result holds in the result register; the input stalls only
//   while that register is full and the receiver stalls, so a new word enters
//   in the same cycle the old result leaves.
//   Reset clears the counters and the result valid flag, and loads register
//   defaults: position 0,0, size 1x1, keyed copy, key and fill 0.
module sprite_blitter_clip_key_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [sbck_pkg::IDX_W-1:0]         cfg_index,
    input  logic [sbck_pkg::CFG_W-1:0]         cfg_data,
    // pixel input
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [sbck_pkg::COLOR_W-1:0]       src_color,
    // result output
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               write_en,
    output logic [sbck_pkg::X_W-1:0]           screen_x,
    output logic [sbck_pkg::Y_W-1:0]           screen_y,
    output logic [sbck_pkg::COLOR_W-1:0]       out_color,
    output logic                               sprite_done
);

`include "assert_macros.svh"

    // Configuration registers
    logic signed [sbck_pkg::DEST_W-1:0]  dest_x_reg;
    logic signed [sbck_pkg::DEST_W-1:0]  dest_y_reg;
    logic [sbck_pkg::SIDE_W-1:0]         sprite_width_reg;
    logic [sbck_pkg::SIDE_W-1:0]         sprite_height_reg;
    logic [sbck_pkg::MODE_W-1:0]         blit_mode_reg;
    logic [sbck_pkg::COLOR_W-1:0]        transparent_key_reg;
    logic [sbck_pkg::COLOR_W-1:0]        fill_color_reg;

    // Position counters
    logic [sbck_pkg::CNT_W-1:0]          col_count_reg, col_count_next;
    logic [sbck_pkg::CNT_W-1:0]          row_count_reg, row_count_next;

    // Result register
    logic                                out_valid_reg;
    logic                                write_en_reg, write_en_next;
    logic [sbck_pkg::X_W-1:0]            screen_x_reg, screen_x_next;
    logic [sbck_pkg::Y_W-1:0]            screen_y_reg, screen_y_next;
    logic [sbck_pkg::COLOR_W-1:0]        out_color_reg, out_color_next;
    logic                                sprite_done_reg, sprite_done_next;

    // Datapath
    logic                                accept;
    logic [sbck_pkg::CNT_W-1:0]          col_last;
    logic [sbck_pkg::CNT_W-1:0]          row_last;
    logic                                last_col;
    logic                                last_row;
    logic [sbck_pkg::CNT_W-1:0]          col_pos;
    logic [sbck_pkg::CNT_W-1:0]          row_pos;
    logic [sbck_pkg::CNT_W-1:0]          x_offset;
    logic [sbck_pkg::COORD_W-1:0]        sx;
    logic [sbck_pkg::COORD_W-1:0]        sy;
    logic                                on_screen;
    logic                                is_key;

    // Handshake: take a word whenever the result register is free or draining
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg          <= '0;
            dest_y_reg          <= '0;
            sprite_width_reg    <= sbck_pkg::SIDE_W'(1);
            sprite_height_reg   <= sbck_pkg::SIDE_W'(1);
            blit_mode_reg       <= sbck_pkg::MODE_KEYED;
            transparent_key_reg <= '0;
            fill_color_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbck_pkg::REG_DEST_X:          dest_x_reg <= cfg_data[sbck_pkg::DEST_W-1:0];
                sbck_pkg::REG_DEST_Y:          dest_y_reg <= cfg_data[sbck_pkg::DEST_W-1:0];
                sbck_pkg::REG_SPRITE_WIDTH:    sprite_width_reg  <= cfg_data[sbck_pkg::SIDE_W-1:0];
                sbck_pkg::REG_SPRITE_HEIGHT:   sprite_height_reg <= cfg_data[sbck_pkg::SIDE_W-1:0];
                sbck_pkg::REG_BLIT_MODE:       blit_mode_reg <= cfg_data[sbck_pkg::MODE_W-1:0];
                sbck_pkg::REG_TRANSPARENT_KEY: transparent_key_reg <= cfg_data;
                sbck_pkg::REG_FILL_COLOR:      fill_color_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Position inside the sprite; a counter past the end clamps to the edge
    always_comb
    begin
        col_last = sbck_pkg::side_last(sprite_width_reg);
        row_last = sbck_pkg::side_last(sprite_height_reg);
        last_col = col_count_reg >= col_last;
        last_row = row_count_reg >= row_last;
        col_pos  = last_col ? col_last : col_count_reg;
        row_pos  = last_row ? row_last : row_count_reg;
    end

    // Destination coordinate and clip test
    always_comb
    begin
        if (blit_mode_reg == sbck_pkg::MODE_MIRROR)
            x_offset = col_last - col_pos;
        else
            x_offset = col_pos;
        sx = {{(sbck_pkg::COORD_W-sbck_pkg::DEST_W){dest_x_reg[sbck_pkg::DEST_W-1]}},
              dest_x_reg} + sbck_pkg::COORD_W'(x_offset);
        sy = {{(sbck_pkg::COORD_W-sbck_pkg::DEST_W){dest_y_reg[sbck_pkg::DEST_W-1]}},
              dest_y_reg} + sbck_pkg::COORD_W'(row_pos);
        on_screen = !sx[sbck_pkg::COORD_W-1] && (sx < sbck_pkg::COORD_W'(sbck_pkg::SCREEN_WIDTH))
                 && !sy[sbck_pkg::COORD_W-1] && (sy < sbck_pkg::COORD_W'(sbck_pkg::SCREEN_HEIGHT));
        is_key = src_color == transparent_key_reg;
    end

    // Color select and result word
    always_comb
    begin
        write_en_next    = 1'b0;
        out_color_next   = '0;
        screen_x_next    = '0;
        screen_y_next    = '0;
        sprite_done_next = last_col & last_row;
        if (on_screen)
        begin
            if (!is_key)
            begin
                write_en_next  = 1'b1;
                out_color_next = src_color;
            end
            else if (blit_mode_reg == sbck_pkg::MODE_FILL)
            begin
                write_en_next  = 1'b1;
                out_color_next = fill_color_reg;
            end
        end
        if (write_en_next)
        begin
            screen_x_next = sx[sbck_pkg::X_W-1:0];
            screen_y_next = sy[sbck_pkg::Y_W-1:0];
        end
    end

    // Counter advance, row-major with wrap at the sprite end
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_count_next = '0;
                row_count_next = last_row ? '0 : row_count_reg + 1'b1;
            end
            else
            begin
                col_count_next = col_count_reg + 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded on acceptance only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            write_en_reg    <= write_en_next;
            screen_x_reg    <= screen_x_next;
            screen_y_reg    <= screen_y_next;
            out_color_reg   <= out_color_next;
            sprite_done_reg <= sprite_done_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign write_en    = write_en_reg;
    assign screen_x    = screen_x_reg;
    assign screen_y    = screen_y_reg;
    assign out_color   = out_color_reg;
    assign sprite_done = sprite_done_reg;

    // Checks
    `SBCK_ASSERT(a_idle_fields_zero,
        (out_valid && !write_en) |-> (screen_x == '0 && screen_y == '0 && out_color == '0),
        "skipped pixel carries nonzero fields")
    `SBCK_ASSERT(a_write_on_screen,
        (out_valid && write_en) |-> (int'(screen_x) < sbck_pkg::SCREEN_WIDTH
            && int'(screen_y) < sbck_pkg::SCREEN_HEIGHT),
        "write outside the screen")
    `SBCK_ASSERT(a_done_wraps_counters,
        (accept && last_col && last_row) |=> (col_count_reg == '0 && row_count_reg == '0
            && sprite_done && out_valid),
        "sprite end did not wrap the counters")
    `SBCK_ASSERT_ALWAYS(a_stall_needs_result,
        in_stall |-> out_valid,
        "input stalled with an empty result register")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for sprite_blitter_clip_key_top: directed pixel table, then random sprites.
// Expected words come from a local blitter model with its own counters and register copy, or from fixed table entries.
// Depends on sbck_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_top;

    // One result word as the block reports it
    typedef struct packed {
        logic        wr;
        logic [8:0]  x;
        logic [7:0]  y;
        logic [15:0] color;
        logic        done;
    } pix_res_t;

    // Full register set of one sprite setup
    typedef struct {
        int dx;
        int dy;
        int w;
        int h;
        int mode;
        int key;
        int fill;
    } sprite_cfg_t;

    // Directed row: optional register load, one pixel, optional fixed expectation
    typedef struct {
        int          cfg_sel;
        logic [15:0] color;
        bit          typed;
        pix_res_t    want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = sbck_pkg::REG_DEST_X;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] src_color = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        write_en;
    logic [8:0]  screen_x;
    logic [7:0]  screen_y;
    logic [15:0] out_color;
    logic        sprite_done;

    // Register copy and sprite position of the local model
    logic signed [10:0] sh_dx = '0;
    logic signed [10:0] sh_dy = '0;
    logic [8:0]         sh_w = 9'd1;
    logic [8:0]         sh_h = 9'd1;
    logic [1:0]         sh_mode = sbck_pkg::MODE_KEYED;
    logic [15:0]        sh_key = '0;
    logic [15:0]        sh_fill = '0;
    int                 col_pos = 0;
    int                 row_pos = 0;

    pix_res_t blit_q[$];
    int       err_cnt = 0;
    int       sent_cnt = 0;
    bit       quiet = 1'b0;
    bit       long_hold = 1'b0;

    sprite_blitter_clip_key_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .src_color   (src_color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .write_en    (write_en),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .out_color   (out_color),
        .sprite_done (sprite_done)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #400000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Blitter model: place one pixel, clip, pick color, step counters
    function automatic pix_res_t blit_pixel(input logic [15:0] color);
        int       w;
        int       h;
        int       c;
        int       r;
        int       sx;
        int       sy;
        bit       last_c;
        bit       last_r;
        bit       visible;
        pix_res_t res;
        w = (sh_w == 0 || sh_w > sbck_pkg::MAX_SPRITE_SIDE) ? sbck_pkg::MAX_SPRITE_SIDE
                                                             : int'(sh_w);
        h = (sh_h == 0 || sh_h > sbck_pkg::MAX_SPRITE_SIDE) ? sbck_pkg::MAX_SPRITE_SIDE
                                                             : int'(sh_h);
        last_c = col_pos >= w - 1;
        last_r = row_pos >= h - 1;
        c = last_c ? w - 1 : col_pos;
        r = last_r ? h - 1 : row_pos;
        sx = int'(sh_dx) + ((sh_mode == sbck_pkg::MODE_MIRROR) ? (w - 1 - c) : c);
        sy = int'(sh_dy) + r;
        visible = sx >= 0 && sx < sbck_pkg::SCREEN_WIDTH
               && sy >= 0 && sy < sbck_pkg::SCREEN_HEIGHT;
        res = '0;
        if (visible && (color != sh_key || sh_mode == sbck_pkg::MODE_FILL))
        begin
            res.wr    = 1'b1;
            res.x     = 9'(sx);
            res.y     = 8'(sy);
            res.color = (color != sh_key) ? color : sh_fill;
        end
        res.done = last_c && last_r;
        if (last_c)
        begin
            col_pos = 0;
            row_pos = last_r ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            err_cnt++;
        end
    endfunction

    // Result side: compare each accepted word with the oldest pending one
    always @(posedge clk)
    begin : result_check
        pix_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (blit_q.size() == 0)
            begin
                $error("result word with no pixel pending");
                err_cnt++;
            end
            else
            begin
                want = blit_q.pop_front();
                check_field("write_en", 16'(want.wr), 16'(write_en));
                check_field("screen_x", 16'(want.x), 16'(screen_x));
                check_field("screen_y", 16'(want.y), 16'(screen_y));
                check_field("out_color", want.color, out_color);
                check_field("sprite_done", 16'(want.done), 16'(sprite_done));
            end
        end
    end

    // Receiver: random stall bursts, one long hold on request, none when quiet
    initial
    begin : receiver
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (40) @(negedge clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Register write; the model copy follows at the same edge
    task automatic write_reg(input sbck_pkg::cfg_reg_t idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            sbck_pkg::REG_DEST_X:          sh_dx = data[10:0];
            sbck_pkg::REG_DEST_Y:          sh_dy = data[10:0];
            sbck_pkg::REG_SPRITE_WIDTH:    sh_w = data[8:0];
            sbck_pkg::REG_SPRITE_HEIGHT:   sh_h = data[8:0];
            sbck_pkg::REG_BLIT_MODE:       sh_mode = data[1:0];
            sbck_pkg::REG_TRANSPARENT_KEY: sh_key = data;
            sbck_pkg::REG_FILL_COLOR:      sh_fill = data;
            default:                       ;
        endcase
    endtask

    task automatic load_regs(input sprite_cfg_t c);
        write_reg(sbck_pkg::REG_DEST_X, 16'(c.dx));
        write_reg(sbck_pkg::REG_DEST_Y, 16'(c.dy));
        write_reg(sbck_pkg::REG_SPRITE_WIDTH, 16'(c.w));
        write_reg(sbck_pkg::REG_SPRITE_HEIGHT, 16'(c.h));
        write_reg(sbck_pkg::REG_BLIT_MODE, 16'(c.mode));
        write_reg(sbck_pkg::REG_TRANSPARENT_KEY, 16'(c.key));
        write_reg(sbck_pkg::REG_FILL_COLOR, 16'(c.fill));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drop valid and wait until every pending result word is out
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (blit_q.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Offer one pixel, hold it until taken, then maybe leave a gap
    task automatic send_pixel(input logic [15:0] color, input bit typed, input pix_res_t want);
        pix_res_t p;
        @(negedge clk);
        in_valid  <= 1'b1;
        src_color <= color;
        do @(posedge clk); while (in_stall);
        p = blit_pixel(color);
        if (typed)
            p = want;
        blit_q = {blit_q, p};
        sent_cnt++;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            in_valid  <= 1'b0;
            src_color <= 16'($urandom);
            repeat ($urandom_range(1, 14) - 1) @(negedge clk);
        end
    endtask

    // Random sprite setup, mostly near the screen and small
    function automatic sprite_cfg_t pick_cfg();
        sprite_cfg_t c;
        int          odd_side[4] = '{0, 256, 257, 511};
        c.dx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 360) - 20
                                          : $urandom_range(0, 2047) - 1024;
        c.dy = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 280) - 20
                                          : $urandom_range(0, 2047) - 1024;
        c.w = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8)
            : (($urandom_range(0, 1) == 0) ? odd_side[$urandom_range(0, 3)]
                                           : $urandom_range(9, 255));
        c.h = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8)
            : (($urandom_range(0, 1) == 0) ? odd_side[$urandom_range(0, 3)]
                                           : $urandom_range(9, 255));
        c.mode = $urandom_range(0, 3);
        c.key  = $urandom_range(0, 65535);
        c.fill = $urandom_range(0, 65535);
        return c;
    endfunction

    // Directed setups: bottom-right corner, mirrored at negative origin, fill,
    // unused mode, zero sides off screen, then a shrink mid-sprite
    sprite_cfg_t dir_cfg[6] = '{
        '{318, 238, 2, 2, sbck_pkg::MODE_KEYED, 16'hF81F, 0},
        '{-1, -1, 3, 2, sbck_pkg::MODE_MIRROR, 16'h0001, 0},
        '{100, 50, 2, 1, sbck_pkg::MODE_FILL, 16'hABCD, 16'h07E0},
        '{5, 5, 1, 1, 3, 16'hFFFF, 0},
        '{-1024, 1023, 0, 0, sbck_pkg::MODE_KEYED, 0, 16'h5555},
        '{0, 0, 2, 511, sbck_pkg::MODE_KEYED, 0, 0}
    };

    dir_row_t dir_rows[21] = '{
        // reset setup: 1x1 at the origin, key 0
        '{-1, 16'h1234, 1'b1, '{1'b1, 9'd0, 8'd0, 16'h1234, 1'b1}},
        '{-1, 16'h0000, 1'b1, '{1'b0, 9'd0, 8'd0, 16'h0000, 1'b1}},
        '{0, 16'hFFFF, 1'b1, '{1'b1, 9'd318, 8'd238, 16'hFFFF, 1'b0}},
        '{-1, 16'hF81F, 1'b1, '{1'b0, 9'd0, 8'd0, 16'h0000, 1'b0}},
        '{-1, 16'h0000, 1'b1, '{1'b1, 9'd318, 8'd239, 16'h0000, 1'b0}},
        '{-1, 16'hFFFF, 1'b1, '{1'b1, 9'd319, 8'd239, 16'hFFFF, 1'b1}},
        '{1, 16'h0001, 1'b0, '0},
        '{-1, 16'h1111, 1'b0, '0},
        '{-1, 16'h2222, 1'b0, '0},
        '{-1, 16'h3333, 1'b0, '0},
        '{-1, 16'h0001, 1'b0, '0},
        '{-1, 16'h4444, 1'b0, '0},
        '{2, 16'hABCD, 1'b1, '{1'b1, 9'd100, 8'd50, 16'h07E0, 1'b0}},
        '{-1, 16'h1234, 1'b1, '{1'b1, 9'd101, 8'd50, 16'h1234, 1'b1}},
        '{3, 16'hFFFF, 1'b1, '{1'b0, 9'd0, 8'd0, 16'h0000, 1'b1}},
        '{-1, 16'h0000, 1'b1, '{1'b1, 9'd5, 8'd5, 16'h0000, 1'b1}},
        '{4, 16'h8000, 1'b1, '{1'b0, 9'd0, 8'd0, 16'h0000, 1'b0}},
        '{-1, 16'h0001, 1'b1, '{1'b0, 9'd0, 8'd0, 16'h0000, 1'b0}},
        '{-1, 16'h7FFF, 1'b1, '{1'b0, 9'd0, 8'd0, 16'h0000, 1'b0}},
        '{5, 16'h4321, 1'b0, '0},
        '{-1, 16'h8765, 1'b0, '0}
    };

    // Main sequence
    initial
    begin : stimulus
        sprite_cfg_t cfg;
        int          weff;
        int          heff;
        int          n;
        bit          hold_done;
        logic [15:0] color;
        hold_done = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg_sel >= 0)
            begin
                settle();
                load_regs(dir_cfg[dir_rows[i].cfg_sel]);
            end
            send_pixel(dir_rows[i].color, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random sprites, often cut short so the next setup lands mid-sprite
        while (sent_cnt < 550)
        begin
            cfg = pick_cfg();
            settle();
            load_regs(cfg);
            weff = (cfg.w == 0 || cfg.w > sbck_pkg::MAX_SPRITE_SIDE) ? sbck_pkg::MAX_SPRITE_SIDE
                                                                     : cfg.w;
            heff = (cfg.h == 0 || cfg.h > sbck_pkg::MAX_SPRITE_SIDE) ? sbck_pkg::MAX_SPRITE_SIDE
                                                                     : cfg.h;
            if (weff * heff <= 64 && $urandom_range(0, 3) != 0)
                n = weff * heff * $urandom_range(1, 2);
            else
                n = $urandom_range(1, 40);
            // long receiver hold while pixels keep coming
            if (!hold_done && sent_cnt >= 250)
            begin
                long_hold = 1'b1;
                hold_done = 1'b1;
                n = 30;
            end
            if (sent_cnt >= 470)
                quiet = 1'b1;
            repeat (n)
            begin
                color = ($urandom_range(0, 3) == 0) ? 16'(cfg.key) : 16'($urandom);
                send_pixel(color, 1'b0, '0);
            end
        end

        settle();
        repeat (5) @(posedge clk);
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
